/* design/rpa_pkg.sv */
// Shared types, codes and defaults for the reference-counted page allocator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

  // Default sizing, handed down from the top level
  localparam int DEF_MAX_PAGES  = 32768;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int DEF_COUNT_BITS = 8;

  // Field widths fixed by the interface
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int NCOUNT_W  = 8;
  localparam int BASE_W    = 20;
  localparam int PCOUNT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Pool index as carried through the queue: wide enough for any pool size
  localparam int IDX_FIELD_W = 20;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_REF = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROP_REF = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALIGN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT = 2'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] page_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   given_address;
    logic [NCOUNT_W-1:0] new_count;
    logic                returned_to_pool;
  } out_item_t;

  // Classified request as queued for the back end
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic                   in_range;
    logic                   misaligned;
    logic [IDX_FIELD_W-1:0] idx;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

/* design/rpa_front.sv */
// Front end: takes requests, works out the pool index, range and alignment.
// Depends on rpa_pkg; feeds rpa_queue.
`timescale 1ns / 1ps
`default_nettype none

module rpa_front #(
  parameter int MAX_PAGES  = rpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = rpa_pkg::DEF_PAGE_SHIFT
) (
  input  wire                            in_valid,
  output logic                           in_stall,
  input  rpa_pkg::in_item_t              in_data,
  input  wire [rpa_pkg::BASE_W-1:0]      pool_base,
  input  wire [rpa_pkg::PCOUNT_W-1:0]    pool_count,
  input  rpa_pkg::queue_status_t         q_status,
  input  wire                            clearing,
  output logic                           q_push,
  output rpa_pkg::queue_entry_t          q_entry
);
  import rpa_pkg::*;

  localparam int CMP_W = ADDR_W + 1;

  logic [CMP_W-1:0] pnum;
  logic [CMP_W-1:0] base_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pool_eff;
  logic [CMP_W-1:0] diff;
  logic [ADDR_W-1:0] offs_mask;

  // Page number and its offset from the pool base
  assign pnum      = CMP_W'(in_data.page_address >> PAGE_SHIFT);
  assign base_ext  = CMP_W'(pool_base);
  assign count_ext = CMP_W'(pool_count);
  assign pool_eff  = (count_ext < CMP_W'(MAX_PAGES)) ? count_ext : CMP_W'(MAX_PAGES);
  assign diff      = pnum - base_ext;
  assign offs_mask = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

  // Hold off while the queue is full or the count memory is being cleared
  assign in_stall = q_status.full | clearing;
  assign q_push   = in_valid & ~in_stall;

  always_comb begin
    q_entry.kind       = in_data.kind;
    q_entry.in_range   = (pnum >= base_ext) && (diff < pool_eff);
    q_entry.misaligned = |(in_data.page_address & offs_mask);
    q_entry.idx        = diff[IDX_FIELD_W-1:0];
  end

endmodule

`default_nettype wire

/* design/rpa_queue.sv */
// Short request queue between the front end and the back end.
// Depends on rpa_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module rpa_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  rpa_pkg::queue_entry_t   push_entry,
  input  wire                     pop,
  output rpa_pkg::queue_entry_t   pop_entry,
  output rpa_pkg::queue_status_t  status
);
  import rpa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;

  assign status.full  = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (fill_r == '0);
  assign pop_entry    = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* design/rpa_back.sv */
// Back end: free stack, reference count memory and result register.
// Depends on rpa_pkg; pops classified requests from rpa_queue.
`timescale 1ns / 1ps
`default_nettype none

module rpa_back #(
  parameter int MAX_PAGES  = rpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = rpa_pkg::DEF_PAGE_SHIFT,
  parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire [rpa_pkg::BASE_W-1:0]   pool_base,
  input  rpa_pkg::queue_status_t      q_status,
  input  rpa_pkg::queue_entry_t       q_entry,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  wire                         out_stall,
  output rpa_pkg::out_item_t          out_data
);
  import rpa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PAGES);
  localparam int FILL_W = $clog2(MAX_PAGES + 1);
  localparam int SUM_W  = BASE_W + 1;
  localparam int WIDE_W = 2 * ADDR_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_CNT  = 2'd2;

  // Memories
  logic [IDX_W-1:0]      stk_mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_PAGES];

  logic [1:0]            state_r, state_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  clearing_r, clearing_nxt;
  logic [IDX_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic                  misal_r, misal_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  stk_re, stk_we;
  logic [IDX_W-1:0]      stk_raddr, stk_waddr, stk_wdata;
  logic [IDX_W-1:0]      stk_rdata_r;
  logic                  cnt_re, cnt_we;
  logic [IDX_W-1:0]      cnt_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata_r;

  logic                  can_start;
  logic                  out_load;
  logic [COUNT_BITS-1:0] c_cur, c_new;
  logic [15:0]           c_ext;
  logic [SUM_W-1:0]      page_sum;
  logic [WIDE_W-1:0]     addr_wide;

  assign clearing  = clearing_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new request may start when the queue holds one, no clearing pass runs and the result slot is free or draining
  assign can_start = !clearing_r && !q_status.empty && (!out_valid_r || !out_stall);

  assign c_cur     = cnt_rdata_r;
  assign page_sum  = SUM_W'(pool_base) + SUM_W'(idx_r);
  assign addr_wide = WIDE_W'(page_sum) << PAGE_SHIFT;

  // Request sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    kind_nxt     = kind_r;
    misal_nxt    = misal_r;
    idx_nxt      = idx_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    stk_re       = 1'b0;
    stk_raddr    = fill_r[IDX_W-1:0] - IDX_W'(1);
    stk_we       = 1'b0;
    stk_waddr    = fill_r[IDX_W-1:0];
    stk_wdata    = idx_r;
    cnt_re       = 1'b0;
    cnt_raddr    = idx_r;
    cnt_we       = 1'b0;
    cnt_waddr    = idx_r;
    cnt_wdata    = '0;
    c_new        = c_cur;
    c_ext        = '0;

    // Clearing pass over the count memory after reset
    if (clearing_r) begin
      cnt_we       = 1'b1;
      cnt_waddr    = clr_addr_r;
      cnt_wdata    = '0;
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(MAX_PAGES - 1)) begin
        clearing_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (can_start) begin
          q_pop     = 1'b1;
          kind_nxt  = q_entry.kind;
          misal_nxt = q_entry.misaligned;
          idx_nxt   = q_entry.idx[IDX_W-1:0];
          if (q_entry.kind == KIND_ALLOC) begin
            if (fill_r == '0) begin
              out_load     = 1'b1;
              out_data_nxt = '{status: ST_EMPTY, default: '0};
            end else begin
              stk_re    = 1'b1;
              fill_nxt  = fill_r - FILL_W'(1);
              state_nxt = S_POP;
            end
          end else if (!q_entry.in_range) begin
            out_load     = 1'b1;
            out_data_nxt = '{status: ST_RANGE, default: '0};
          end else begin
            cnt_re    = 1'b1;
            cnt_raddr = q_entry.idx[IDX_W-1:0];
            state_nxt = S_CNT;
          end
        end
      end
      S_POP: begin
        // Popped index is now in the stack read register
        idx_nxt   = stk_rdata_r;
        cnt_re    = 1'b1;
        cnt_raddr = stk_rdata_r;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        out_load     = 1'b1;
        out_data_nxt = '{status: ST_OK, default: '0};
        state_nxt    = S_IDLE;
        unique case (kind_r)
          KIND_ALLOC: begin
            c_new = (c_cur < CNT_MAX) ? c_cur + COUNT_BITS'(1) : c_cur;
            cnt_we = 1'b1;
            cnt_wdata = c_new;
            out_data_nxt.given_address = addr_wide[ADDR_W-1:0];
          end
          KIND_RELEASE: begin
            if (c_cur > COUNT_BITS'(1)) begin
              c_new     = c_cur - COUNT_BITS'(1);
              cnt_we    = 1'b1;
              cnt_wdata = c_new;
            end else if (misal_r) begin
              out_data_nxt.status = ST_ALIGN;
            end else if (fill_r == FILL_W'(MAX_PAGES)) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              // Page goes back on the free stack
              c_new     = '0;
              cnt_we    = 1'b1;
              cnt_wdata = '0;
              stk_we    = 1'b1;
              fill_nxt  = fill_r + FILL_W'(1);
              out_data_nxt.returned_to_pool = 1'b1;
            end
          end
          KIND_ADD_REF: begin
            c_new     = (c_cur < CNT_MAX) ? c_cur + COUNT_BITS'(1) : c_cur;
            cnt_we    = 1'b1;
            cnt_wdata = c_new;
          end
          KIND_DROP_REF: begin
            c_new     = (c_cur != '0) ? c_cur - COUNT_BITS'(1) : c_cur;
            cnt_we    = 1'b1;
            cnt_wdata = c_new;
          end
          default: begin
            c_new = c_cur;
          end
        endcase
        c_ext                  = 16'(c_new);
        out_data_nxt.new_count = c_ext[NCOUNT_W-1:0];
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Result slot
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    misal_r <= misal_nxt;
    idx_r   <= idx_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  // Reference count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_PAGES))
    else $error("free stack fill beyond pool capacity");

  a_no_work_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !q_pop && (state_r == S_IDLE))
    else $error("request started during count clearing");

  a_cnt_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT) |=> (state_r == S_IDLE))
    else $error("count step did not finish the request");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT) |-> !out_valid_r)
    else $error("result slot still occupied at completion");

  a_pop_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> $past(q_pop) && ($past(fill_r) != '0))
    else $error("stack pop without a queued allocate");

endmodule

`default_nettype wire

/* design/refcounted_page_allocator_core.sv */
// Reference-counted page allocator, top level.
// Depends on rpa_pkg, rpa_front, rpa_queue and rpa_back.
//
// Requests arrive on in_valid / in_stall / in_data and are taken at an edge
// with in_valid high and in_stall low. Every request gives one result on
// out_valid / out_stall / out_data; the result register holds while
// out_stall is high and the back end waits for it, the two-entry queue
// behind the front end keeps taking requests until it fills.
// Pool registers are written on cfg_valid / cfg_ready (always ready),
// index 0 the base page number, index 1 the page count; the user must
// write them only while idle, as the block does not enforce it.
// A rejected request is answered straight from the queue head; release
// and reference updates read the count, then write it unless a release
// is refused; an allocate reads the stack, then the count, then writes
// it. One request per cycle is taken when rejected and out_stall is low;
// any other request finishes its steps before the next one is taken.
// After reset the stack is empty and a clearing pass writes zero to every
// count, with in_stall held high; config writes still go.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_page_allocator_core #(
  parameter int MAX_PAGES  = rpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = rpa_pkg::DEF_PAGE_SHIFT,
  parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  rpa_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output rpa_pkg::out_item_t             out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rpa_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import rpa_pkg::*;

  logic [BASE_W-1:0]   pool_base_r;
  logic [PCOUNT_W-1:0] pool_count_r;
  logic                q_push, q_pop, clearing;
  queue_entry_t        q_in, q_out;
  queue_status_t       q_status;

  // Pool configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      pool_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POOL_BASE:  pool_base_r  <= cfg_data[BASE_W-1:0];
        REG_POOL_COUNT: pool_count_r <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  rpa_front #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .pool_base  (pool_base_r),
    .pool_count (pool_count_r),
    .q_status   (q_status),
    .clearing   (clearing),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  rpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .status     (q_status)
  );

  rpa_back #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool_base (pool_base_r),
    .q_status  (q_status),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
